/* design/rlsar_pkg.sv */
// Shared constants, types and saturation helpers of the RLS AR predictor.
`default_nettype none

package rlsar_pkg;

	localparam int AR_ORDER    = 4;
	localparam int NCOEF       = AR_ORDER + 1;
	localparam int NCOV        = NCOEF * NCOEF;
	localparam int MAX_HORIZON = 16;
	localparam int QW          = 48;
	localparam int AW          = QW + 4;
	localparam int IW          = $clog2(NCOEF);
	localparam int CW          = $clog2(NCOV);
	localparam int FW          = $clog2(AR_ORDER);

	localparam logic signed [QW-1:0] LIM48    = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [QW-1:0] ONE_Q    = 48'sd65536;
	localparam logic signed [QW-1:0] PI_Q     = 48'sd205887;
	localparam logic signed [QW-1:0] TWO_PI_Q = 48'sd411774;
	localparam logic signed [QW-1:0] COV_INIT = 48'sd6553600;
	localparam logic [16:0]          Q16_ONE  = 17'd65536;

	localparam logic [1:0] STAT_WARM = 2'd0;
	localparam logic [1:0] STAT_JUMP = 2'd1;
	localparam logic [1:0] STAT_PRED = 2'd2;

	localparam logic [2:0] CFG_HORIZON = 3'd0;
	localparam logic [2:0] CFG_FORGET  = 3'd1;
	localparam logic [2:0] CFG_REG     = 3'd2;
	localparam logic [2:0] CFG_SCALE   = 3'd3;
	localparam logic [2:0] CFG_ANGLE   = 3'd4;
	localparam logic [2:0] CFG_ALPHA   = 3'd5;
	localparam logic [2:0] CFG_JUMP    = 3'd6;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_ISSUE  = 8'b0000_0010,
		ST_WAIT   = 8'b0000_0100,
		ST_HIST   = 8'b0000_1000,
		ST_FCINIT = 8'b0001_0000,
		ST_FIN    = 8'b0010_0000,
		ST_EMA    = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	typedef enum logic [10:0] {
		PH_WRAP = 11'b000_0000_0001,
		PH_ERR  = 11'b000_0000_0010,
		PH_V    = 11'b000_0000_0100,
		PH_DEN  = 11'b000_0000_1000,
		PH_GDIV = 11'b000_0001_0000,
		PH_GMUL = 11'b000_0010_0000,
		PH_W    = 11'b000_0100_0000,
		PH_NMUL = 11'b000_1000_0000,
		PH_NDIV = 11'b001_0000_0000,
		PH_SYM  = 11'b010_0000_0000,
		PH_FC   = 11'b100_0000_0000
	} phase_t;

	function automatic logic signed [QW-1:0] sat48(input logic signed [63:0] v);
		logic signed [63:0] lim;
		lim = 64'(LIM48);
		if (v > lim) begin
			return LIM48;
		end else if (v < -lim) begin
			return -LIM48;
		end
		return QW'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return 32'(v);
	endfunction

	function automatic logic [QW-1:0] mag48(input logic signed [QW-1:0] v);
		return v[QW-1] ? QW'(-v) : QW'(v);
	endfunction

endpackage

`default_nettype wire

/* design/rlsar_mul.sv */
// Shared Q32.16 multiplier: 48 by 16 bits per cycle, truncates toward zero, saturates.
`default_nettype none

module rlsar_mul import rlsar_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [QW-1:0] a,
	input  wire logic signed [QW-1:0] b,
	output logic                      done,
	output logic signed [QW-1:0]      y
);

	logic          busy_q, done_q, neg_q;
	logic [1:0]    cnt_q;
	logic [QW-1:0] ma_q, mb_q;
	logic [95:0]   p_q, p_n;
	logic [79:0]   q_n;
	logic signed [QW-1:0] m_n, y_q;

	always_comb begin
		p_n = {p_q[79:0], 16'b0} + 96'(ma_q) * 96'(mb_q[47:32]);
		q_n = p_n[95:16];
		m_n = (|q_n[79:47]) ? LIM48 : $signed({1'b0, q_n[46:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			ma_q   <= '0;
			mb_q   <= '0;
			p_q    <= '0;
			y_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ma_q   <= mag48(a);
				mb_q   <= mag48(b);
				neg_q  <= a[QW-1] ^ b[QW-1];
				p_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				p_q   <= p_n;
				mb_q  <= {mb_q[31:0], 16'b0};
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					y_q    <= neg_q ? -m_n : m_n;
				end
			end
		end
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

`default_nettype wire

/* design/rlsar_div.sv */
// Shared restoring divider: one quotient bit per cycle over a 64-bit numerator.
`default_nettype none

module rlsar_div import rlsar_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [63:0]   num,
	input  wire logic [QW-1:0] den,
	output logic               done,
	output logic [63:0]        quo,
	output logic [QW-1:0]      rem
);

	logic          busy_q, done_q, ge;
	logic [5:0]    cnt_q;
	logic [63:0]   n_q, q_q;
	logic [QW-1:0] r_q, d_q, r_n;
	logic [QW:0]   t;

	always_comb begin
		t   = {r_q, n_q[63]};
		ge  = (t >= {1'b0, d_q});
		r_n = ge ? QW'(t - {1'b0, d_q}) : t[QW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			n_q    <= '0;
			q_q    <= '0;
			r_q    <= '0;
			d_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				n_q    <= num;
				d_q    <= den;
				r_q    <= '0;
				q_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				r_q   <= r_n;
				q_q   <= {q_q[62:0], ge};
				n_q   <= {n_q[62:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

`default_nettype wire

/* design/rls_ar_multistep_predictor_core.sv */
// Top level of the adaptive RLS AR multi-step position predictor.
//
// Usage: one position sample (with a forecast horizon) enters on the s_ stream
// and exactly one result leaves on the m_ stream for every input transfer.
// The first four samples only fill the difference history and return a
// warming-up result with value zero. Later samples run one RLS update of the
// AR(4)-plus-bias model (skipped if its gain denominator is <= 0) and a k-step
// forecast, then return the raw sample (the forecast sum jumped) or the EMA-smoothed
// prediction. Throughput: one item at a time; s_tready is high only while idle.
// A warming item uses no shared unit (in angle mode the divider once, for the wrap).
// A full item runs the 64-step shared divider 30 times (gains and covariance
// scaling) and the shared multiplier 90 times plus 4 per forecast step.
// Results sit in an output register; if the receiver stalls, the next item is
// still accepted and computed, and waits only for the register to free up.
// Reset (arst_n low) restores the register defaults, clears the model, sets the
// covariance to the default initial scale times identity and drops any result.
// A write of initial_scale has no effect, since it applies only at reset,
// which restores its default too. Write registers only while the block is idle.
`default_nettype none

module rls_ar_multistep_predictor_core import rlsar_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] sample, [36:32] horizon, zero fill above
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] value
	output logic [1:0]       m_tuser,   // [1:0] status
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	// Configuration registers.
	logic [4:0]  dh_q;
	logic [16:0] ff_q, alpha_q;
	logic [15:0] reg_q;
	logic        angle_q;
	logic [30:0] jl_q;

	// Sequencer and model state.
	state_t state_q;
	phase_t phase_q;
	logic [IW-1:0] i_q, j_q, hcnt_q;
	logic [4:0]    hz_q, step_q;
	logic          half_q, started_q;
	logic signed [31:0] prev_q, sample_q, diff_q, pfs_q, ema_q, pred_q;
	logic signed [31:0] hist_q [NCOEF];
	logic signed [33:0] wrap_q;
	logic signed [QW-1:0] coef_q [NCOEF];
	logic signed [QW-1:0] cov_q [NCOV];
	logic signed [QW-1:0] np_q [NCOV];
	logic signed [QW-1:0] v_q [NCOEF];
	logic signed [QW-1:0] w_q [NCOEF];
	logic signed [QW-1:0] gain_q [NCOEF];
	logic signed [QW-1:0] fh_q [AR_ORDER];
	logic signed [QW-1:0] err_q, den_q, tmp_q, total_q;
	logic signed [AW-1:0] acc_q;
	logic [1:0]  res_stat_q, m_tuser_q;
	logic [31:0] res_val_q, m_tdata_q;
	logic        m_tvalid_q;

	// Shared units.
	logic mul_start, mul_done, div_start, div_done;
	logic signed [QW-1:0] mul_a, mul_b, mul_y;
	logic [63:0]   div_num, div_quo;
	logic [QW-1:0] div_den, div_rem;

	// Combinational helpers.
	logic signed [QW-1:0] x_v [NCOEF];
	logic [CW-1:0] cidx, jidx, np_addr;
	logic signed [QW-1:0] cov_rd, np_rd, acc_sat, div_res, den_n, yhat_n;
	logic signed [AW-1:0] acc_n;
	logic [16:0] ff_eff, alpha_eff;
	logic [4:0]  hz_in, hz_a, hz_b, hz_eff;
	logic signed [31:0] sample_in, sum32, pred_n, ema_n;
	logic signed [32:0] diff_raw, jump_d, ema_d;
	logic [32:0]  jump_abs;
	logic signed [50:0] ema_m;
	logic signed [QW:0] sym_sum;
	logic signed [QW-1:0] sym_half, wrap_t;
	logic div_neg, last_i, last_j, out_load;

	rlsar_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.y      (mul_y)
	);

	rlsar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	always_comb begin
		// Regressor: the four older differences, then the bias term.
		for (int k = 0; k < NCOEF; k++) begin
			x_v[k] = (k < AR_ORDER) ? QW'(hist_q[(k + 1) % NCOEF]) : ONE_Q;
		end
		cidx    = CW'(i_q * NCOEF + j_q);
		jidx    = CW'(j_q * NCOEF + i_q);
		np_addr = half_q ? jidx : cidx;
		cov_rd  = cov_q[cidx];
		np_rd   = np_q[np_addr];
		last_i  = (i_q == IW'(NCOEF - 1));
		last_j  = (j_q == IW'(NCOEF - 1));

		ff_eff    = (ff_q == '0) ? 17'd1 : ((ff_q > Q16_ONE) ? Q16_ONE : ff_q);
		alpha_eff = (alpha_q > Q16_ONE) ? Q16_ONE : alpha_q;

		sample_in = $signed(s_tdata[31:0]);
		hz_in     = s_tdata[36:32];
		hz_a      = (hz_in == '0) ? dh_q : hz_in;
		hz_b      = (hz_a == '0) ? 5'd1 : hz_a;
		hz_eff    = (hz_b > 5'(MAX_HORIZON)) ? 5'(MAX_HORIZON) : hz_b;
		diff_raw  = 33'(sample_in) - 33'(prev_q);

		acc_n   = acc_q + AW'(mul_y);
		acc_sat = sat48(64'(acc_n));
		den_n   = sat48(64'(ff_eff) + 64'(acc_sat) + 64'(reg_q));
		yhat_n  = sat48(64'(acc_sat) + 64'(coef_q[AR_ORDER]));

		// Quotient of a Q division: saturate, then apply the dividend's sign.
		div_neg = (phase_q == PH_GDIV) ? v_q[i_q][QW-1] : tmp_q[QW-1];
		div_res = (|div_quo[63:QW-1]) ? LIM48 : $signed({1'b0, div_quo[QW-2:0]});
		if (div_neg) begin
			div_res = -div_res;
		end

		// Angle wrap from the remainder of |d + pi| by two pi.
		wrap_t = (wrap_q[33] && div_rem != '0) ? TWO_PI_Q - $signed(div_rem) : $signed(div_rem);
		wrap_t = wrap_t - PI_Q;

		// Symmetrising halves toward zero.
		sym_sum  = (QW + 1)'(tmp_q) + (QW + 1)'(np_rd);
		sym_half = QW'((sym_sum + (QW + 1)'(sym_sum[QW])) >>> 1);

		sum32    = sat32(64'(total_q));
		jump_d   = 33'(sum32) - 33'(pfs_q);
		jump_abs = jump_d[32] ? 33'(-jump_d) : 33'(jump_d);
		pred_n   = sat32(64'(sample_q) + 64'(sum32));
		ema_d    = 33'(pred_q) - 33'(ema_q);
		ema_m    = $signed({1'b0, alpha_eff}) * ema_d;
		ema_n    = ema_q + 32'(ema_m >>> 16);

		// The output register takes a new result when it is free or draining.
		out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

		mul_a   = '0;
		mul_b   = '0;
		div_num = '0;
		div_den = '0;
		unique case (phase_q)
			PH_WRAP: begin
				div_num = 64'(wrap_q[33] ? 34'(-wrap_q) : 34'(wrap_q));
				div_den = TWO_PI_Q;
			end
			PH_ERR: begin
				mul_a = x_v[i_q];
				mul_b = coef_q[i_q];
			end
			PH_V: begin
				mul_a = cov_rd;
				mul_b = x_v[j_q];
			end
			PH_DEN: begin
				mul_a = x_v[i_q];
				mul_b = v_q[i_q];
			end
			PH_GDIV: begin
				div_num = {mag48(v_q[i_q]), 16'b0};
				div_den = den_q;
			end
			PH_GMUL: begin
				mul_a = gain_q[i_q];
				mul_b = err_q;
			end
			PH_W: begin
				mul_a = x_v[i_q];
				mul_b = cov_rd;
			end
			PH_NMUL: begin
				mul_a = gain_q[i_q];
				mul_b = w_q[j_q];
			end
			PH_NDIV: begin
				div_num = {mag48(tmp_q), 16'b0};
				div_den = QW'(ff_eff);
			end
			PH_FC: begin
				mul_a = coef_q[i_q];
				mul_b = fh_q[i_q[FW-1:0]];
			end
			PH_SYM: begin
			end
			default: begin
			end
		endcase

		mul_start = (state_q == ST_ISSUE) && (phase_q == PH_ERR || phase_q == PH_V ||
			phase_q == PH_DEN || phase_q == PH_GMUL || phase_q == PH_W ||
			phase_q == PH_NMUL || phase_q == PH_FC);
		div_start = (state_q == ST_ISSUE) && (phase_q == PH_WRAP || phase_q == PH_GDIV ||
			phase_q == PH_NDIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dh_q       <= 5'd1;
			ff_q       <= 17'd64881;
			reg_q      <= '0;
			angle_q    <= 1'b0;
			alpha_q    <= 17'd19661;
			jl_q       <= 31'd1310720;
			state_q    <= ST_IDLE;
			phase_q    <= PH_ERR;
			i_q        <= '0;
			j_q        <= '0;
			hcnt_q     <= '0;
			hz_q       <= '0;
			step_q     <= '0;
			half_q     <= 1'b0;
			started_q  <= 1'b0;
			prev_q     <= '0;
			sample_q   <= '0;
			diff_q     <= '0;
			pfs_q      <= '0;
			ema_q      <= '0;
			pred_q     <= '0;
			wrap_q     <= '0;
			err_q      <= '0;
			den_q      <= '0;
			tmp_q      <= '0;
			total_q    <= '0;
			acc_q      <= '0;
			res_stat_q <= STAT_WARM;
			res_val_q  <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= STAT_WARM;
			for (int k = 0; k < NCOEF; k++) begin
				hist_q[k] <= '0;
				coef_q[k] <= '0;
				v_q[k]    <= '0;
				w_q[k]    <= '0;
				gain_q[k] <= '0;
			end
			for (int k = 0; k < AR_ORDER; k++) begin
				fh_q[k] <= '0;
			end
			for (int k = 0; k < NCOV; k++) begin
				cov_q[k] <= (k % (NCOEF + 1) == 0) ? COV_INIT : '0;
				np_q[k]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HORIZON: dh_q    <= cfg_data[4:0];
					CFG_FORGET:  ff_q    <= cfg_data[16:0];
					CFG_REG:     reg_q   <= cfg_data[15:0];
					CFG_SCALE: begin
						// The scale only shapes the reset covariance.
					end
					CFG_ANGLE:   angle_q <= cfg_data[0];
					CFG_ALPHA:   alpha_q <= cfg_data[16:0];
					CFG_JUMP:    jl_q    <= cfg_data[30:0];
					default: begin
					end
				endcase
			end

			if (m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						sample_q <= sample_in;
						hz_q     <= hz_eff;
						if (angle_q) begin
							wrap_q  <= 34'(diff_raw) + 34'(PI_Q);
							phase_q <= PH_WRAP;
							state_q <= ST_ISSUE;
						end else begin
							diff_q  <= sat32(64'(diff_raw));
							state_q <= ST_HIST;
						end
					end
				end
				ST_HIST: begin
					for (int k = NCOEF - 1; k > 0; k--) begin
						hist_q[k] <= hist_q[k - 1];
					end
					hist_q[0] <= diff_q;
					prev_q    <= sample_q;
					if (hcnt_q < IW'(NCOEF - 1)) begin
						hcnt_q     <= hcnt_q + IW'(1);
						res_stat_q <= STAT_WARM;
						res_val_q  <= '0;
						state_q    <= ST_OUT;
					end else begin
						hcnt_q  <= IW'(NCOEF);
						phase_q <= PH_ERR;
						i_q     <= '0;
						j_q     <= '0;
						acc_q   <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (phase_q == PH_SYM) begin
						if (!half_q) begin
							tmp_q  <= np_rd;
							half_q <= 1'b1;
						end else begin
							half_q <= 1'b0;
							cov_q[cidx] <= (i_q == j_q) ?
								sat48(64'(sym_half) + 64'(reg_q)) : sym_half;
							if (last_j) begin
								j_q <= '0;
								if (last_i) begin
									state_q <= ST_FCINIT;
								end else begin
									i_q <= i_q + IW'(1);
								end
							end else begin
								j_q <= j_q + IW'(1);
							end
						end
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (mul_done || div_done) begin
						unique case (phase_q)
							PH_WRAP: begin
								diff_q  <= 32'(wrap_t);
								state_q <= ST_HIST;
							end
							PH_ERR: begin
								state_q <= ST_ISSUE;
								if (last_i) begin
									err_q   <= sat48(64'(hist_q[0]) - 64'(acc_sat));
									acc_q   <= '0;
									i_q     <= '0;
									j_q     <= '0;
									phase_q <= PH_V;
								end else begin
									acc_q <= acc_n;
									i_q   <= i_q + IW'(1);
								end
							end
							PH_V: begin
								state_q <= ST_ISSUE;
								if (last_j) begin
									v_q[i_q] <= acc_sat;
									acc_q    <= '0;
									j_q      <= '0;
									if (last_i) begin
										i_q     <= '0;
										phase_q <= PH_DEN;
									end else begin
										i_q <= i_q + IW'(1);
									end
								end else begin
									acc_q <= acc_n;
									j_q   <= j_q + IW'(1);
								end
							end
							PH_DEN: begin
								if (last_i) begin
									den_q <= den_n;
									acc_q <= '0;
									i_q   <= '0;
									if (den_n <= 0) begin
										// No usable gain: keep the model as it is.
										state_q <= ST_FCINIT;
									end else begin
										phase_q <= PH_GDIV;
										state_q <= ST_ISSUE;
									end
								end else begin
									acc_q   <= acc_n;
									i_q     <= i_q + IW'(1);
									state_q <= ST_ISSUE;
								end
							end
							PH_GDIV: begin
								gain_q[i_q] <= div_res;
								phase_q     <= PH_GMUL;
								state_q     <= ST_ISSUE;
							end
							PH_GMUL: begin
								coef_q[i_q] <= sat48(64'(coef_q[i_q]) + 64'(mul_y));
								state_q     <= ST_ISSUE;
								if (last_i) begin
									i_q     <= '0;
									j_q     <= '0;
									acc_q   <= '0;
									phase_q <= PH_W;
								end else begin
									i_q     <= i_q + IW'(1);
									phase_q <= PH_GDIV;
								end
							end
							PH_W: begin
								state_q <= ST_ISSUE;
								if (last_i) begin
									w_q[j_q] <= acc_sat;
									acc_q    <= '0;
									i_q      <= '0;
									if (last_j) begin
										j_q     <= '0;
										phase_q <= PH_NMUL;
									end else begin
										j_q <= j_q + IW'(1);
									end
								end else begin
									acc_q <= acc_n;
									i_q   <= i_q + IW'(1);
								end
							end
							PH_NMUL: begin
								tmp_q   <= sat48(64'(cov_rd) - 64'(mul_y));
								phase_q <= PH_NDIV;
								state_q <= ST_ISSUE;
							end
							PH_NDIV: begin
								np_q[cidx] <= div_res;
								state_q    <= ST_ISSUE;
								if (last_j) begin
									j_q <= '0;
									if (last_i) begin
										i_q     <= '0;
										half_q  <= 1'b0;
										phase_q <= PH_SYM;
									end else begin
										i_q     <= i_q + IW'(1);
										phase_q <= PH_NMUL;
									end
								end else begin
									j_q     <= j_q + IW'(1);
									phase_q <= PH_NMUL;
								end
							end
							PH_FC: begin
								if (i_q == IW'(AR_ORDER - 1)) begin
									total_q <= sat48(64'(total_q) + 64'(yhat_n));
									for (int k = AR_ORDER - 1; k > 0; k--) begin
										fh_q[k] <= fh_q[k - 1];
									end
									fh_q[0] <= yhat_n;
									acc_q   <= '0;
									i_q     <= '0;
									if (5'(step_q + 5'd1) == hz_q) begin
										state_q <= ST_FIN;
									end else begin
										step_q  <= step_q + 5'd1;
										state_q <= ST_ISSUE;
									end
								end else begin
									acc_q   <= acc_n;
									i_q     <= i_q + IW'(1);
									state_q <= ST_ISSUE;
								end
							end
							PH_SYM: begin
								state_q <= ST_ISSUE;
							end
							default: begin
								state_q <= ST_ISSUE;
							end
						endcase
					end
				end
				ST_FCINIT: begin
					for (int k = 0; k < AR_ORDER; k++) begin
						fh_q[k] <= QW'(hist_q[k + 1]);
					end
					i_q     <= '0;
					j_q     <= '0;
					step_q  <= '0;
					acc_q   <= '0;
					total_q <= '0;
					phase_q <= PH_FC;
					state_q <= ST_ISSUE;
				end
				ST_FIN: begin
					pfs_q <= sum32;
					if (jump_abs > {2'b0, jl_q}) begin
						res_stat_q <= STAT_JUMP;
						res_val_q  <= sample_q;
						state_q    <= ST_OUT;
					end else if (!started_q) begin
						ema_q      <= pred_n;
						started_q  <= 1'b1;
						res_stat_q <= STAT_PRED;
						res_val_q  <= pred_n;
						state_q    <= ST_OUT;
					end else begin
						pred_q  <= pred_n;
						state_q <= ST_EMA;
					end
				end
				ST_EMA: begin
					ema_q      <= ema_n;
					res_stat_q <= STAT_PRED;
					res_val_q  <= ema_n;
					state_q    <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_val_q;
						m_tuser_q  <= res_stat_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// An accepted item keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// A warming-up result always carries a zero value.
	a_warm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_WARM) |-> (m_tdata == '0))
		else $error("warming result with nonzero value");

	// Only one shared unit runs at a time.
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && div_done))
		else $error("multiplier and divider finished together");

	// A new result is loaded only into a free or draining output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) && m_tvalid && !m_tready |=> (state_q == ST_OUT))
		else $error("result overwrote a stalled output");

endmodule

`default_nettype wire
